>>> rtl/core/nine_point_stencil_apply_top_defines.svh
// ----------------------------------------------------------------------------
// Nine-point stencil: assertion macros
// Shared concurrent check macros, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef NINE_POINT_STENCIL_APPLY_TOP_DEFINES_SVH
`define NINE_POINT_STENCIL_APPLY_TOP_DEFINES_SVH

// same-cycle implication
`define NSA_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nsa_pkg.sv
// ----------------------------------------------------------------------------
// Nine-point stencil package
// Widths, types, register codes, reset values and arithmetic helpers.
// ----------------------------------------------------------------------------
package nsa_pkg;

  localparam int SAMPLE_W         = 24;
  localparam int COEF_W           = 16;
  localparam int COEF_REG_W       = 3 * COEF_W;
  localparam int GRID_W           = 6;
  localparam int IDX_W            = 5;
  localparam int RESULT_W         = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int TAPS             = 3;
  localparam int PROD_W           = SAMPLE_W + COEF_W;
  localparam int ROW_W            = PROD_W + 2;
  localparam int TOTAL_W          = ROW_W + 2;
  localparam int FRAC_SHIFT       = 8;
  localparam int MAX_GRID_DEFAULT = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [COEF_REG_W-1:0]      coef_reg_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ROW_W-1:0]    row_sum_t;
  typedef logic signed [TOTAL_W-1:0]  total_t;
  typedef logic signed [RESULT_W-1:0] result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE   = 2'd0,
    REG_COEF_ABOVE  = 2'd1,
    REG_COEF_CENTER = 2'd2,
    REG_COEF_BELOW  = 2'd3
  } reg_idx_t;

  localparam logic [GRID_W-1:0] GRID_SIZE_RESET   = 6'd16;
  localparam coef_reg_t         COEF_ABOVE_RESET  = 48'hFE00_FF00_FE00;
  localparam coef_reg_t         COEF_CENTER_RESET = 48'hFF00_0C00_FF00;
  localparam coef_reg_t         COEF_BELOW_RESET  = 48'hFE00_FF00_FE00;

  localparam total_t ROUND_BIAS = total_t'(1) <<< (FRAC_SHIFT - 1);
  localparam total_t RES_MAX    = total_t'(result_t'({1'b0, {(RESULT_W-1){1'b1}}}));
  localparam total_t RES_MIN    = total_t'(result_t'({1'b1, {(RESULT_W-1){1'b0}}}));

  // Grid position tag carried alongside each result
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } tag_t;

  // Exact signed product of a Q12.12 sample and a Q8.8 weight
  function automatic prod_t mul_tap(sample_t s, coef_t w);
    prod_t a;
    prod_t b;
    a = prod_t'(s);
    b = prod_t'(w);
    return a * b;
  endfunction

  // Weight k of a packed register: 0 left, 1 centre, 2 right
  function automatic coef_t coef_pick(coef_reg_t word, int unsigned k);
    return coef_t'(word[COEF_REG_W - 1 - COEF_W * k -: COEF_W]);
  endfunction

endpackage

>>> rtl/core/nsa_cell.sv
// ----------------------------------------------------------------------------
// Nine-point stencil line cell
// One sample of a line delay; loads the new word or takes its neighbor's.
// ----------------------------------------------------------------------------
module nsa_cell (
  input  logic             clk,
  input  logic             shift,
  input  logic             load,
  input  nsa_pkg::sample_t din,
  input  nsa_pkg::sample_t prev,
  output nsa_pkg::sample_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= load ? din : prev;
    end
  end

endmodule

>>> rtl/core/nsa_line.sv
// ----------------------------------------------------------------------------
// Nine-point stencil line delay
// Chain of cells with a movable entry point; delay is DEPTH - inj_idx shifts.
// ----------------------------------------------------------------------------
module nsa_line #(
  parameter int DEPTH = nsa_pkg::MAX_GRID_DEFAULT + 1
) (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [$clog2(DEPTH)-1:0]   inj_idx,
  input  nsa_pkg::sample_t           din,
  output nsa_pkg::sample_t           dout
);

  localparam int IW = $clog2(DEPTH);

  nsa_pkg::sample_t q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    nsa_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .load (IW'(i) == inj_idx),
      .din  (din),
      .prev ((i == 0) ? din : q[(i == 0) ? 0 : i - 1]),
      .q    (q[i])
    );
  end

  assign dout = q[DEPTH-1];

endmodule

>>> rtl/core/nsa_sum.sv
// ----------------------------------------------------------------------------
// Nine-point stencil arithmetic
// Products, row sums, rounded total, then saturation into the output word.
// ----------------------------------------------------------------------------
module nsa_sum (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               emit,
  input  nsa_pkg::tag_t      tag,
  input  nsa_pkg::sample_t   tap [nsa_pkg::TAPS][nsa_pkg::TAPS],
  input  nsa_pkg::coef_reg_t coef [nsa_pkg::TAPS],
  output logic               valid,
  output nsa_pkg::result_t   result,
  output nsa_pkg::tag_t      tag_q
);

  nsa_pkg::prod_t    prod [nsa_pkg::TAPS][nsa_pkg::TAPS];
  nsa_pkg::row_sum_t rsum [nsa_pkg::TAPS];
  nsa_pkg::total_t   total;
  nsa_pkg::total_t   shifted;
  nsa_pkg::result_t  result_next;
  nsa_pkg::tag_t     tag1;
  nsa_pkg::tag_t     tag2;
  nsa_pkg::tag_t     tag3;
  logic              v1;
  logic              v2;
  logic              v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v1    <= emit;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < nsa_pkg::TAPS; i++) begin
        for (int j = 0; j < nsa_pkg::TAPS; j++) begin
          prod[i][j] <= nsa_pkg::mul_tap(tap[i][j], nsa_pkg::coef_pick(coef[i], j));
        end
        rsum[i] <= nsa_pkg::row_sum_t'(prod[i][0]) + nsa_pkg::row_sum_t'(prod[i][1])
                 + nsa_pkg::row_sum_t'(prod[i][2]);
      end
      total  <= nsa_pkg::total_t'(rsum[0]) + nsa_pkg::total_t'(rsum[1])
              + nsa_pkg::total_t'(rsum[2]) + nsa_pkg::ROUND_BIAS;
      result <= result_next;
      tag1   <= tag;
      tag2   <= tag1;
      tag3   <= tag2;
      tag_q  <= tag3;
    end
  end

  // floor shift to the Q20.12 result scale, then clamp to the result range
  always_comb begin
    shifted = total >>> nsa_pkg::FRAC_SHIFT;
    if (shifted > nsa_pkg::RES_MAX) begin
      result_next = nsa_pkg::result_t'(nsa_pkg::RES_MAX);
    end else if (shifted < nsa_pkg::RES_MIN) begin
      result_next = nsa_pkg::result_t'(nsa_pkg::RES_MIN);
    end else begin
      result_next = shifted[nsa_pkg::RESULT_W-1:0];
    end
  end

endmodule

>>> rtl/core/nine_point_stencil_apply_top.sv
// ----------------------------------------------------------------------------
// Nine-point stencil apply
// Applies a 3x3 weight stencil to an N x N grid streamed in raster order.
// ----------------------------------------------------------------------------
// Samples enter one per cycle unless stalled. Each grid row is followed by
// one internal zero column slot, and each frame by one internal zero row of
// N+1 slots, during which in_stall is high; a frame of N x N samples spans
// (N+1)^2 slots, set by the single slot sequencer that feeds the two line
// delays (chains of MAX_GRID+1 cells, entry point moved by grid_size). The
// result for point (r,c) leaves the product, row sum, total and result
// registers after the slot carrying its lower-right neighbor; the last zero
// row flushes the final grid row. Values outside the grid count as zero.
// Writing grid_size restarts the frame at (0,0). Slots hold while a register
// write is offered, and output stalls propagate back to the input.
// ----------------------------------------------------------------------------
`include "nine_point_stencil_apply_top_defines.svh"

module nine_point_stencil_apply_top #(
  parameter int MAX_GRID = nsa_pkg::MAX_GRID_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nsa_pkg::COEF_REG_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [nsa_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [nsa_pkg::RESULT_W-1:0] result,
  output logic [nsa_pkg::IDX_W-1:0]           out_row,
  output logic [nsa_pkg::IDX_W-1:0]           out_col,
  output logic                                frame_last
);

  localparam int PW = $clog2(MAX_GRID + 1);

  function automatic logic [PW-1:0] eff_grid(logic [nsa_pkg::GRID_W-1:0] v);
    if (v == '0) begin
      return PW'(1);
    end else if (v > nsa_pkg::GRID_W'(MAX_GRID)) begin
      return PW'(MAX_GRID);
    end
    return PW'(v);
  endfunction

  logic [PW-1:0]      grid_n;
  nsa_pkg::coef_reg_t coef [nsa_pkg::TAPS];
  logic [PW-1:0]      pos_row;
  logic [PW-1:0]      pos_col;
  logic               pad;
  logic               adv;
  logic               slot_fire;
  logic               emit;
  logic               cfg_fire;
  nsa_pkg::sample_t   slot_val;
  nsa_pkg::sample_t   line1_q;
  nsa_pkg::sample_t   line2_q;
  nsa_pkg::sample_t   cur [nsa_pkg::TAPS];
  nsa_pkg::sample_t   win1 [nsa_pkg::TAPS];
  nsa_pkg::sample_t   win2 [nsa_pkg::TAPS];
  nsa_pkg::sample_t   tap [nsa_pkg::TAPS][nsa_pkg::TAPS];
  logic [PW-1:0]      inj_idx;
  nsa_pkg::tag_t      tag;
  nsa_pkg::tag_t      tag_q;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // slot at the zero column or zero row needs no input word
  assign pad       = (pos_col == grid_n) || (pos_row == grid_n);
  assign adv       = !out_valid || !out_stall;
  // hold the slot sequencer while a register write is offered
  assign in_stall  = !(adv && !pad && !cfg_valid);
  assign slot_fire = adv && !cfg_valid && (pad || in_valid);
  assign emit      = slot_fire && (pos_row != '0) && (pos_col != '0);
  assign slot_val  = pad ? '0 : sample;
  assign inj_idx   = PW'(MAX_GRID) - grid_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_n  <= eff_grid(nsa_pkg::GRID_SIZE_RESET);
      coef[0] <= nsa_pkg::COEF_ABOVE_RESET;
      coef[1] <= nsa_pkg::COEF_CENTER_RESET;
      coef[2] <= nsa_pkg::COEF_BELOW_RESET;
      pos_row <= '0;
      pos_col <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        nsa_pkg::REG_GRID_SIZE: begin
          grid_n  <= eff_grid(cfg_data[nsa_pkg::GRID_W-1:0]);
          pos_row <= '0;
          pos_col <= '0;
        end
        nsa_pkg::REG_COEF_ABOVE:  coef[0] <= cfg_data;
        nsa_pkg::REG_COEF_CENTER: coef[1] <= cfg_data;
        nsa_pkg::REG_COEF_BELOW:  coef[2] <= cfg_data;
        default: ;
      endcase
    end else if (slot_fire) begin
      if (pos_col == grid_n) begin
        pos_col <= '0;
        pos_row <= (pos_row == grid_n) ? '0 : pos_row + PW'(1);
      end else begin
        pos_col <= pos_col + PW'(1);
      end
    end
  end

  nsa_line #(.DEPTH(MAX_GRID + 1)) u_line1 (
    .clk    (clk),
    .shift  (slot_fire),
    .inj_idx(inj_idx),
    .din    (slot_val),
    .dout   (line1_q)
  );

  nsa_line #(.DEPTH(MAX_GRID + 1)) u_line2 (
    .clk    (clk),
    .shift  (slot_fire),
    .inj_idx(inj_idx),
    .din    (line1_q),
    .dout   (line2_q)
  );

  assign cur[0] = line2_q;
  assign cur[1] = line1_q;
  assign cur[2] = slot_val;

  always_ff @(posedge clk) begin
    if (slot_fire) begin
      win2 <= win1;
      win1 <= cur;
    end
  end

  // drop the row above on the first result row, the left column on column 0
  always_comb begin
    for (int i = 0; i < nsa_pkg::TAPS; i++) begin
      tap[i][0] = (pos_col == PW'(1)) ? '0 : win2[i];
      tap[i][1] = win1[i];
      tap[i][2] = cur[i];
      if (i == 0 && pos_row == PW'(1)) begin
        tap[i][0] = '0;
        tap[i][1] = '0;
        tap[i][2] = '0;
      end
    end
  end

  assign tag.row  = nsa_pkg::IDX_W'(pos_row - PW'(1));
  assign tag.col  = nsa_pkg::IDX_W'(pos_col - PW'(1));
  assign tag.last = (pos_row == grid_n) && (pos_col == grid_n);

  nsa_sum u_sum (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .emit  (emit),
    .tag   (tag),
    .tap   (tap),
    .coef  (coef),
    .valid (out_valid),
    .result(result),
    .tag_q (tag_q)
  );

  assign out_row    = tag_q.row;
  assign out_col    = tag_q.col;
  assign frame_last = tag_q.last;

  `NSA_CHECK(a_last_is_corner, out_valid && frame_last,
    (out_row == nsa_pkg::IDX_W'(grid_n - PW'(1))) && (out_col == nsa_pkg::IDX_W'(grid_n - PW'(1))),
    "frame_last away from the bottom-right corner")
  `NSA_CHECK(a_pos_in_range, 1'b1, (pos_row <= grid_n) && (pos_col <= grid_n),
    "slot position beyond the padded grid")
  `NSA_CHECK_NEXT(a_pos_holds, !adv && !cfg_valid, $stable(pos_row) && $stable(pos_col),
    "slot position moved while the pipeline was held")

endmodule
